@@ hw/rtl/apt_pkg.sv @@
// Shared types and constants for the affine point transform block.
package apt_pkg;

    // Width of every data port and of each stored matrix coefficient.
    localparam int DATA_W    = 32;
    localparam int MAT_DEPTH = 16;
    localparam int IDX_W     = 4;
    localparam int OP_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_POINT  = 2'd1,
        OP_VECTOR = 2'd2
    } op_t;

    // Load enables for the five pipeline stages of a row lane.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } apt_en_t;

endpackage

@@ hw/rtl/apt_mat_store.sv @@
// Matrix coefficient store: sixteen words, identity after reset.
module apt_mat_store #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [apt_pkg::IDX_W-1:0]   wr_idx,
    input  logic [apt_pkg::DATA_W-1:0]  wr_data,
    output logic [apt_pkg::DATA_W-1:0]  mat_o [apt_pkg::MAT_DEPTH]
);
    import apt_pkg::*;

    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    logic [DATA_W-1:0] mat_reg [MAT_DEPTH];

    for (genvar g = 0; g < MAT_DEPTH; g++) begin : g_entry
        // Diagonal entries sit at every fifth position in column-major order.
        localparam logic [DATA_W-1:0] RST_VAL = ((g % 5) == 0) ? ONE : '0;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mat_reg[g] <= RST_VAL;
            end else if (wr_en && (wr_idx == IDX_W'(g))) begin
                mat_reg[g] <= wr_data;
            end
        end

        assign mat_o[g] = mat_reg[g];
    end

endmodule

@@ hw/rtl/apt_row_lane.sv @@
// One output row: three multiplies, translation add, floor shift and saturation.
module apt_row_lane #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                        aclk,
    input  apt_pkg::apt_en_t            en,
    input  logic                        point,
    input  logic [apt_pkg::DATA_W-1:0]  coef_i [3],
    input  logic [apt_pkg::DATA_W-1:0]  trans_i,
    input  logic [apt_pkg::DATA_W-1:0]  vec_i [3],
    output logic [apt_pkg::DATA_W-1:0]  res_o,
    output logic                        sat_o
);
    import apt_pkg::*;

    localparam int OPW    = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
    localparam int PROD_W = 2 * OPW;
    localparam int TR_W   = OPW + FRAC_BITS;
    localparam int MAX_W  = (PROD_W > TR_W) ? PROD_W : TR_W;
    localparam int ACC_W  = MAX_W + 2;

    logic signed [OPW-1:0]    c_reg [3];
    logic signed [OPW-1:0]    v_reg [3];
    logic signed [OPW-1:0]    t_reg;
    logic signed [PROD_W-1:0] p_reg [3];
    logic signed [OPW-1:0]    t2_reg;
    logic signed [ACC_W-1:0]  sa_reg;
    logic signed [ACC_W-1:0]  sb_reg;
    logic signed [ACC_W-1:0]  sum_reg;
    logic [DATA_W-1:0]        res_reg;
    logic                     sat_reg;

    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-OPW:0]       hi_bits;
    logic                     fits;
    logic signed [OPW-1:0]    clip;

    // Stage 1: operands, taken as signed words of the arithmetic width.
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= coef_i[i][OPW-1:0];
                v_reg[i] <= vec_i[i][OPW-1:0];
            end
            t_reg <= point ? trans_i[OPW-1:0] : '0;
        end
    end

    // Stage 2: exact products.
    always_ff @(posedge aclk) begin
        if (en.s2) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[i] <= PROD_W'(c_reg[i]) * PROD_W'(v_reg[i]);
            end
            t2_reg <= t_reg;
        end
    end

    // Stage 3: two partial sums; the translation is scaled to product weight.
    always_ff @(posedge aclk) begin
        if (en.s3) begin
            sa_reg <= ACC_W'(p_reg[0]) + ACC_W'(p_reg[1]);
            sb_reg <= ACC_W'(p_reg[2]) + (ACC_W'(t2_reg) <<< FRAC_BITS);
        end
    end

    // Stage 4: full sum.
    always_ff @(posedge aclk) begin
        if (en.s4) begin
            sum_reg <= sa_reg + sb_reg;
        end
    end

    // Stage 5: floor shift, then the value fits when all bits above the
    // result's sign bit agree with it.
    always_comb begin
        shifted = sum_reg >>> FRAC_BITS;
        hi_bits = shifted[ACC_W-1:OPW-1];
        fits    = (&hi_bits) || !(|hi_bits);
        if (fits) begin
            clip = shifted[OPW-1:0];
        end else if (shifted[ACC_W-1]) begin
            clip = {1'b1, {(OPW-1){1'b0}}};
        end else begin
            clip = {1'b0, {(OPW-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            res_reg <= DATA_W'(clip);
            sat_reg <= !fits;
        end
    end

    assign res_o = res_reg;
    assign sat_o = sat_reg;

endmodule

@@ hw/rtl/affine_point_transform_top.sv @@
// A transform beat's result reaches the result port through every stage register.
// Throughput: one beat per cycle; stalls on the result side back up stage by stage.
// Coefficient loads complete in the cycle they are accepted and give no result.
// Unused opcodes are accepted and dropped.
// Reset (aresetn low, synchronous) empties the pipeline and restores the identity matrix.
module affine_point_transform_top #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [apt_pkg::OP_W-1:0]    s_opcode,
    input  logic [apt_pkg::IDX_W-1:0]   s_coef_index,
    input  logic [apt_pkg::DATA_W-1:0]  s_coef_value,
    input  logic [apt_pkg::DATA_W-1:0]  s_in_x,
    input  logic [apt_pkg::DATA_W-1:0]  s_in_y,
    input  logic [apt_pkg::DATA_W-1:0]  s_in_z,
    input  logic                        s_last_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [apt_pkg::DATA_W-1:0]  m_out_x,
    output logic [apt_pkg::DATA_W-1:0]  m_out_y,
    output logic [apt_pkg::DATA_W-1:0]  m_out_z,
    output logic                        m_saturated,
    output logic                        m_last_out
);
    import apt_pkg::*;

    localparam int NST = 5;

    logic [NST-1:0]    vld_reg;
    logic [NST-1:0]    vld_next;
    logic [NST-1:0]    last_reg;
    logic [NST-1:0]    rdy;
    logic              is_xform;
    logic              is_point;
    logic              fire;
    apt_en_t           en;
    logic [DATA_W-1:0] mat [MAT_DEPTH];
    logic [DATA_W-1:0] vec [3];
    logic [DATA_W-1:0] row_res [3];
    logic [2:0]        row_sat;

    assign is_point = (s_opcode == OP_POINT);
    assign is_xform = is_point || (s_opcode == OP_VECTOR);

    // A stage can take a beat when it is empty or its own beat moves on.
    always_comb begin
        rdy[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_ready = rdy[0];
    assign fire    = s_valid && rdy[0];

    assign en.s1 = fire && is_xform;
    assign en.s2 = rdy[1] && vld_reg[0];
    assign en.s3 = rdy[2] && vld_reg[1];
    assign en.s4 = rdy[3] && vld_reg[2];
    assign en.s5 = rdy[4] && vld_reg[3];

    always_comb begin
        vld_next = vld_reg;
        if (rdy[0]) begin
            vld_next[0] = fire && is_xform;
        end
        for (int k = 1; k < NST; k++) begin
            if (rdy[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) last_reg[0] <= s_last_in;
        if (en.s2) last_reg[1] <= last_reg[0];
        if (en.s3) last_reg[2] <= last_reg[1];
        if (en.s4) last_reg[3] <= last_reg[2];
        if (en.s5) last_reg[4] <= last_reg[3];
    end

    apt_mat_store #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (fire && (s_opcode == OP_LOAD)),
        .wr_idx  (s_coef_index),
        .wr_data (s_coef_value),
        .mat_o   (mat)
    );

    assign vec[0] = s_in_x;
    assign vec[1] = s_in_y;
    assign vec[2] = s_in_z;

    // Row r uses entries r, 4+r and 8+r, with translation at 12+r.
    for (genvar r = 0; r < 3; r++) begin : g_row
        logic [DATA_W-1:0] coef [3];

        assign coef[0] = mat[r];
        assign coef[1] = mat[4 + r];
        assign coef[2] = mat[8 + r];

        apt_row_lane #(
            .FRAC_BITS  (FRAC_BITS),
            .WORD_WIDTH (WORD_WIDTH)
        ) u_lane (
            .aclk    (aclk),
            .en      (en),
            .point   (is_point),
            .coef_i  (coef),
            .trans_i (mat[12 + r]),
            .vec_i   (vec),
            .res_o   (row_res[r]),
            .sat_o   (row_sat[r])
        );
    end

    assign m_valid     = vld_reg[NST-1];
    assign m_out_x     = row_res[0];
    assign m_out_y     = row_res[1];
    assign m_out_z     = row_res[2];
    assign m_saturated = |row_sat;
    assign m_last_out  = last_reg[NST-1];

endmodule

@@ hw/rtl/apt_checker.sv @@
// Port-level checks for the affine point transform, bound to its top level.
module apt_checker #(
    parameter int WORD_WIDTH = 32
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [apt_pkg::OP_W-1:0]    s_opcode,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [apt_pkg::DATA_W-1:0]  m_out_x,
    input logic [apt_pkg::DATA_W-1:0]  m_out_y,
    input logic [apt_pkg::DATA_W-1:0]  m_out_z,
    input logic                        m_saturated,
    input logic                        m_last_out
);
    import apt_pkg::*;

    localparam int OPW = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
    localparam logic [DATA_W-1:0] SAT_MAX = DATA_W'((64'd1 << (OPW - 1)) - 64'd1);
    localparam logic [DATA_W-1:0] SAT_MIN = ~SAT_MAX;

    logic xform_fire;
    logic sat_hit;

    assign xform_fire = s_valid && s_ready
                        && ((s_opcode == OP_POINT) || (s_opcode == OP_VECTOR));
    assign sat_hit = (m_out_x == SAT_MAX) || (m_out_x == SAT_MIN)
                     || (m_out_y == SAT_MAX) || (m_out_y == SAT_MIN)
                     || (m_out_z == SAT_MAX) || (m_out_z == SAT_MIN);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
            && $stable(m_out_z) && $stable(m_saturated) && $stable(m_last_out))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // With the result side open, a transform's result is valid once it has passed every
    // stage register after its accept.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(xform_fire, 5) && $past(m_ready, 1) && $past(m_ready, 2)
            && $past(m_ready, 3) && $past(m_ready, 4) && $past(aresetn, 1)
            && $past(aresetn, 2) && $past(aresetn, 3) && $past(aresetn, 4)
            && $past(aresetn, 5) |-> m_valid)
        else $error("transform result missing after pipeline latency");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> sat_hit)
        else $error("saturation flagged without a clipped component");

endmodule

bind affine_point_transform_top apt_checker #(
    .WORD_WIDTH (WORD_WIDTH)
) u_apt_checker (.*);
